>>> rtl/tce_pkg.sv
// Package for the triangle conduction element: widths, lane numbering,
// saturation bounds and the item, result and stage structs.
// No dependencies; every other file of the block imports it.
package tce_pkg;

    localparam int COORD_W  = 32;   // input coordinate and temperature width
    localparam int DIFF_W   = 33;   // coordinate difference
    localparam int PROD_W   = 66;   // product of a difference with a difference or temperature
    localparam int DET_W    = 67;   // determinant
    localparam int SUM_W    = 68;   // sums of products
    localparam int MAG_W    = 68;   // magnitude of a sum
    localparam int K_W      = 32;   // conductivity register
    localparam int SPLIT_W  = 32;   // low part of a magnitude in the scaling multiply
    localparam int DEN_W    = 68;   // divisor and partial remainder
    localparam int OUT_W    = 64;   // result field width
    localparam int QBITS    = 64;   // quotient bits produced by the divider

    localparam int PREP_LAT  = 4;
    localparam int SCALE_LAT = 2;
    localparam int DIV_LAT   = QBITS + 2;

    localparam int N_LANES = 8;
    localparam int N_COND  = 6;
    localparam int LANE_C00 = 0;
    localparam int LANE_C01 = 1;
    localparam int LANE_C02 = 2;
    localparam int LANE_C11 = 3;
    localparam int LANE_C12 = 4;
    localparam int LANE_C22 = 5;
    localparam int LANE_FX  = 6;
    localparam int LANE_FY  = 7;

    localparam logic [K_W-1:0] K_RESET = 32'd65536;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [QBITS-1:0]        Q_NEG_LIM = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] node0_x;
        logic signed [COORD_W-1:0] node0_y;
        logic signed [COORD_W-1:0] node1_x;
        logic signed [COORD_W-1:0] node1_y;
        logic signed [COORD_W-1:0] node2_x;
        logic signed [COORD_W-1:0] node2_y;
        logic signed [COORD_W-1:0] temp0;
        logic signed [COORD_W-1:0] temp1;
        logic signed [COORD_W-1:0] temp2;
    } tce_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] area;
        logic signed [OUT_W-1:0] cond_00;
        logic signed [OUT_W-1:0] cond_01;
        logic signed [OUT_W-1:0] cond_02;
        logic signed [OUT_W-1:0] cond_11;
        logic signed [OUT_W-1:0] cond_12;
        logic signed [OUT_W-1:0] cond_22;
        logic signed [OUT_W-1:0] flux_x;
        logic signed [OUT_W-1:0] flux_y;
        logic                    degenerate;
    } tce_result_t;

    // Output of the geometry front end, one set per item.
    typedef struct packed {
        logic [N_LANES-1:0][MAG_W-1:0] mag;
        logic [N_LANES-1:0]            neg;
        logic [DEN_W-1:0]              dmag;
        logic [DEN_W-1:0]              d2mag;
        logic signed [OUT_W-1:0]       area;
        logic                          degenerate;
    } tce_prep_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] area;
        logic                    degenerate;
    } tce_side_t;

endpackage

>>> rtl/tce_if.sv
// Valid/ready channel interfaces for the triangle conduction element.
// Depends on tce_pkg for the item and result structs.
interface tce_item_if;
    import tce_pkg::*;
    logic      valid;
    logic      ready;
    tce_item_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface tce_result_if;
    import tce_pkg::*;
    logic        valid;
    logic        ready;
    tce_result_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

>>> rtl/tce_prep.sv
// Geometry front end: differences, products, determinant, sums, magnitudes
// and area over four register stages. Depends on tce_pkg.
module tce_prep (
    input  logic               clk,
    input  logic               en,
    input  tce_pkg::tce_item_t item,
    output tce_pkg::tce_prep_t prep
);
    import tce_pkg::*;

    localparam int PI [N_COND] = '{0, 0, 0, 1, 1, 2};
    localparam int PJ [N_COND] = '{0, 1, 2, 1, 2, 2};

    logic signed [DIFF_W-1:0]  b_reg [3];
    logic signed [DIFF_W-1:0]  c_reg [3];
    logic signed [COORD_W-1:0] t_reg [3];

    logic signed [PROD_W-1:0] pa_reg;
    logic signed [PROD_W-1:0] pb_reg;
    logic signed [PROD_W-1:0] bb_reg [N_COND];
    logic signed [PROD_W-1:0] cc_reg [N_COND];
    logic signed [PROD_W-1:0] bt_reg [3];
    logic signed [PROD_W-1:0] ct_reg [3];

    logic signed [DET_W-1:0] det_reg;
    logic signed [SUM_W-1:0] s_reg [N_LANES];

    tce_prep_t prep_reg;
    tce_prep_t prep_next;

    logic                    dneg;
    logic signed [DET_W-1:0] half;

    // Stage 1: coordinate differences.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg[0] <= DIFF_W'(item.node1_y) - DIFF_W'(item.node2_y);
            b_reg[1] <= DIFF_W'(item.node2_y) - DIFF_W'(item.node0_y);
            b_reg[2] <= DIFF_W'(item.node0_y) - DIFF_W'(item.node1_y);
            c_reg[0] <= DIFF_W'(item.node2_x) - DIFF_W'(item.node1_x);
            c_reg[1] <= DIFF_W'(item.node0_x) - DIFF_W'(item.node2_x);
            c_reg[2] <= DIFF_W'(item.node1_x) - DIFF_W'(item.node0_x);
            t_reg[0] <= item.temp0;
            t_reg[1] <= item.temp1;
            t_reg[2] <= item.temp2;
        end
    end

    // Stage 2: products. D = c2*b1 - c1*b2.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= c_reg[2] * b_reg[1];
            pb_reg <= c_reg[1] * b_reg[2];
            for (int n = 0; n < N_COND; n++)
            begin
                bb_reg[n] <= b_reg[PI[n]] * b_reg[PJ[n]];
                cc_reg[n] <= c_reg[PI[n]] * c_reg[PJ[n]];
            end
            for (int n = 0; n < 3; n++)
            begin
                bt_reg[n] <= b_reg[n] * t_reg[n];
                ct_reg[n] <= c_reg[n] * t_reg[n];
            end
        end
    end

    // Stage 3: determinant and sums.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= DET_W'(pa_reg) - DET_W'(pb_reg);
            for (int n = 0; n < N_COND; n++)
            begin
                s_reg[n] <= SUM_W'(bb_reg[n]) + SUM_W'(cc_reg[n]);
            end
            s_reg[LANE_FX] <= SUM_W'(bt_reg[0]) + SUM_W'(bt_reg[1]) + SUM_W'(bt_reg[2]);
            s_reg[LANE_FY] <= SUM_W'(ct_reg[0]) + SUM_W'(ct_reg[1]) + SUM_W'(ct_reg[2]);
        end
    end

    // Stage 4: magnitudes, quotient signs and the saturated area.
    always_comb
    begin
        dneg = det_reg[DET_W-1];
        half = det_reg >>> 1;
        prep_next.dmag  = dneg ? DEN_W'(-det_reg) : DEN_W'(det_reg);
        prep_next.d2mag = {prep_next.dmag[DEN_W-2:0], 1'b0};
        for (int n = 0; n < N_LANES; n++)
        begin
            prep_next.mag[n] = s_reg[n][SUM_W-1] ? MAG_W'(-s_reg[n]) : MAG_W'(s_reg[n]);
            if (n < N_COND)
            begin
                prep_next.neg[n] = (s_reg[n][SUM_W-1] == dneg);
            end
            else
            begin
                prep_next.neg[n] = (s_reg[n][SUM_W-1] != dneg);
            end
        end
        if ((&half[DET_W-1:OUT_W-1]) || !(|half[DET_W-1:OUT_W-1]))
        begin
            prep_next.area = half[OUT_W-1:0];
        end
        else
        begin
            prep_next.area = half[DET_W-1] ? OUT_MIN : OUT_MAX;
        end
        prep_next.degenerate = (det_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

    assign prep = prep_reg;

endmodule

>>> rtl/tce_scale.sv
// One lane of numerator scaling: magnitude times conductivity, shifted by
// the fraction bits, in two register stages. Depends on tce_pkg.
module tce_scale #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                          clk,
    input  logic                                          en,
    input  logic [tce_pkg::MAG_W-1:0]                     mag,
    input  logic [tce_pkg::K_W-1:0]                       k,
    input  logic [tce_pkg::DEN_W-1:0]                     den_in,
    input  logic                                          neg_in,
    output logic [tce_pkg::MAG_W+tce_pkg::K_W+FRAC_BITS-1:0] num,
    output logic [tce_pkg::DEN_W-1:0]                     den_out,
    output logic                                          neg_out
);
    import tce_pkg::*;

    localparam int NUM_W = MAG_W + K_W + FRAC_BITS;

    logic [SPLIT_W+K_W-1:0]       pl_reg;
    logic [MAG_W-SPLIT_W+K_W-1:0] ph_reg;
    logic [DEN_W-1:0]             den_reg [2];
    logic                         neg_reg [2];
    logic [NUM_W-1:0]             num_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg     <= mag[SPLIT_W-1:0] * k;
            ph_reg     <= mag[MAG_W-1:SPLIT_W] * k;
            den_reg[0] <= den_in;
            neg_reg[0] <= neg_in;
            num_reg    <= ((NUM_W'(ph_reg) << SPLIT_W) + NUM_W'(pl_reg)) << FRAC_BITS;
            den_reg[1] <= den_reg[0];
            neg_reg[1] <= neg_reg[0];
        end
    end

    assign num     = num_reg;
    assign den_out = den_reg[1];
    assign neg_out = neg_reg[1];

endmodule

>>> rtl/tce_div.sv
// One lane of the pipelined restoring divider: overflow check, one quotient
// bit per stage, then signed saturation. Depends on tce_pkg.
module tce_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                             clk,
    input  logic                                             en,
    input  logic [tce_pkg::MAG_W+tce_pkg::K_W+FRAC_BITS-1:0] num,
    input  logic [tce_pkg::DEN_W-1:0]                        den,
    input  logic                                             neg,
    output logic signed [tce_pkg::OUT_W-1:0]                 quo
);
    import tce_pkg::*;

    localparam int NUM_W = MAG_W + K_W + FRAC_BITS;

    logic [DEN_W-1:0] rem_reg [QBITS+1];
    logic [QBITS-1:0] low_reg [QBITS+1];
    logic [QBITS-1:0] q_reg   [QBITS+1];
    logic [DEN_W-1:0] den_reg [QBITS+1];
    logic             neg_reg [QBITS+1];
    logic             ovf_reg [QBITS+1];

    logic signed [OUT_W-1:0] quo_reg;
    logic signed [OUT_W-1:0] quo_next;

    // A quotient of 2^64 or more shows when the upper numerator bits reach
    // the divisor; otherwise those bits are the starting remainder.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DEN_W'(num[NUM_W-1:QBITS]);
            low_reg[0] <= num[QBITS-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= neg;
            ovf_reg[0] <= (DEN_W'(num[NUM_W-1:QBITS]) >= den);
        end
    end

    for (genvar i = 0; i < QBITS; i++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic           ge;

        always_comb
        begin
            trial = {rem_reg[i], low_reg[i][QBITS-1]};
            ge    = (trial >= {1'b0, den_reg[i]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? DEN_W'(trial - {1'b0, den_reg[i]}) : DEN_W'(trial);
                low_reg[i+1] <= {low_reg[i][QBITS-2:0], 1'b0};
                q_reg[i+1]   <= {q_reg[i][QBITS-2:0], ge};
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end
    end

    always_comb
    begin
        if (!neg_reg[QBITS])
        begin
            quo_next = (ovf_reg[QBITS] || q_reg[QBITS][QBITS-1]) ? OUT_MAX : q_reg[QBITS];
        end
        else if (ovf_reg[QBITS] || (q_reg[QBITS] > Q_NEG_LIM))
        begin
            quo_next = OUT_MIN;
        end
        else
        begin
            quo_next = OUT_W'(-q_reg[QBITS]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

>>> rtl/triangle_conduction_element_top.sv
// Top level of the linear triangle heat-conduction element pipeline.
// Depends on tce_pkg, tce_if, tce_prep, tce_scale and tce_div.
//
// Each item on item_ch is one triangle: three node coordinates and three
// nodal temperatures, signed with FRAC_BITS fraction bits. For each item one
// result leaves on result_ch: the signed area, the six distinct entries of
// the element conductivity matrix, the flux vector and a degenerate flag.
// A zero determinant sets degenerate and forces all other fields to zero.
//
// The user must write the conductivity k through cfg_we/cfg_wdata only while
// the block is idle; the block does not enforce this. Reset loads 1.0 in Q16.16.
//
// Throughput is one item per clock while the pipeline is not frozen by a stall.
// From acceptance to result valid an item passes four geometry stages, two
// scaling-multiply stages and 66 divider stages (one overflow check, one
// quotient bit per stage over 64 bits, one saturation stage), then the output
// register. The divider's bit-per-stage chain sets the latency.
//
// Reset clears all valid bits, the output buffer's included. When the receiver
// stalls, the result held in the output register waits and one more item can
// complete into a spare register; only then does the pipeline freeze and
// item_ch.ready drop. Nothing is dropped or repeated across a stall.
module triangle_conduction_element_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    tce_item_if.sink                  item_ch,
    tce_result_if.source              result_ch,
    input  logic                      cfg_we,
    input  logic [tce_pkg::K_W-1:0]   cfg_wdata
);
    import tce_pkg::*;

    localparam int NUM_W    = MAG_W + K_W + FRAC_BITS;
    localparam int SIDE_LAT = SCALE_LAT + DIV_LAT;
    localparam int PIPE_LAT = PREP_LAT + SIDE_LAT;

    logic [K_W-1:0] k_reg;

    // The whole pipeline moves together unless the spare register is full.
    logic adv;

    logic [PIPE_LAT-1:0] vld_reg;
    tce_side_t           side_reg [SIDE_LAT];

    tce_prep_t prep;

    logic [NUM_W-1:0]        num   [N_LANES];
    logic [DEN_W-1:0]        den   [N_LANES];
    logic                    neg   [N_LANES];
    logic signed [OUT_W-1:0] quo   [N_LANES];

    tce_result_t res;
    logic        pipe_out_v;

    tce_result_t main_reg;
    tce_result_t main_next;
    logic        main_valid_reg;
    logic        main_valid_next;
    tce_result_t spare_reg;
    tce_result_t spare_next;
    logic        spare_valid_reg;
    logic        spare_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_RESET;
        end
        else if (cfg_we)
        begin
            k_reg <= cfg_wdata;
        end
    end

    assign adv           = !spare_valid_reg;
    assign item_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], item_ch.valid};
        end
    end

    tce_prep u_prep (
        .clk  (clk),
        .en   (adv),
        .item (item_ch.item),
        .prep (prep)
    );

    // Area and the degenerate flag ride alongside the scaling and divider lanes.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].area       <= prep.area;
            side_reg[0].degenerate <= prep.degenerate;
            for (int s = 1; s < SIDE_LAT; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // Conductivity lanes divide by 2|D|, flux lanes by |D|.
    for (genvar n = 0; n < N_LANES; n++)
    begin : g_lane
        logic [DEN_W-1:0] den_sel;

        if (n < N_COND)
        begin : g_cond
            assign den_sel = prep.d2mag;
        end
        else
        begin : g_flux
            assign den_sel = prep.dmag;
        end

        tce_scale #(
            .FRAC_BITS (FRAC_BITS)
        ) u_scale (
            .clk     (clk),
            .en      (adv),
            .mag     (prep.mag[n]),
            .k       (k_reg),
            .den_in  (den_sel),
            .neg_in  (prep.neg[n]),
            .num     (num[n]),
            .den_out (den[n]),
            .neg_out (neg[n])
        );

        tce_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num (num[n]),
            .den (den[n]),
            .neg (neg[n]),
            .quo (quo[n])
        );
    end

    // Final assembly, with everything forced to zero for a degenerate triangle.
    always_comb
    begin
        res.degenerate = side_reg[SIDE_LAT-1].degenerate;
        if (res.degenerate)
        begin
            res.area    = '0;
            res.cond_00 = '0;
            res.cond_01 = '0;
            res.cond_02 = '0;
            res.cond_11 = '0;
            res.cond_12 = '0;
            res.cond_22 = '0;
            res.flux_x  = '0;
            res.flux_y  = '0;
        end
        else
        begin
            res.area    = side_reg[SIDE_LAT-1].area;
            res.cond_00 = quo[LANE_C00];
            res.cond_01 = quo[LANE_C01];
            res.cond_02 = quo[LANE_C02];
            res.cond_11 = quo[LANE_C11];
            res.cond_12 = quo[LANE_C12];
            res.cond_22 = quo[LANE_C22];
            res.flux_x  = quo[LANE_FX];
            res.flux_y  = quo[LANE_FY];
        end
    end

    assign pipe_out_v = vld_reg[PIPE_LAT-1] && adv;

    // Output register plus one spare entry.
    always_comb
    begin
        main_next        = main_reg;
        main_valid_next  = main_valid_reg;
        spare_next       = spare_reg;
        spare_valid_next = spare_valid_reg;
        if (!main_valid_reg || result_ch.ready)
        begin
            if (spare_valid_reg)
            begin
                main_next        = spare_reg;
                main_valid_next  = 1'b1;
                spare_valid_next = 1'b0;
            end
            else
            begin
                main_next       = res;
                main_valid_next = pipe_out_v;
            end
        end
        else if (pipe_out_v)
        begin
            spare_next       = res;
            spare_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg  <= main_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg  <= main_next;
        spare_reg <= spare_next;
    end

    assign result_ch.valid = main_valid_reg;
    assign result_ch.item  = main_reg;

    // The spare entry is only ever filled behind a waiting output.
    a_spare_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        spare_valid_reg |-> main_valid_reg)
        else $error("spare entry valid while output register empty");

    a_spare_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(spare_valid_reg) |-> $past(main_valid_reg && !result_ch.ready))
        else $error("spare entry filled without an output stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        item_ch.valid && item_ch.ready |=> vld_reg[0])
        else $error("accepted item did not enter the first stage");

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        main_valid_reg && main_reg.degenerate |->
            main_reg.area == '0 && main_reg.flux_x == '0 && main_reg.flux_y == '0)
        else $error("degenerate result carries nonzero fields");

endmodule
